@@ rtl/perspective_attribute_interpolator_defines.svh @@
// Assertion macros for the perspective attribute interpolator checker.
// Depends on nothing; included by the checker file only.
`ifndef PERSPECTIVE_ATTRIBUTE_INTERPOLATOR_DEFINES_SVH
`define PERSPECTIVE_ATTRIBUTE_INTERPOLATOR_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define PAI_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PAI_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pai_pkg.sv @@
// Shared widths, defaults and types of the perspective attribute interpolator.
// Depends on nothing; used by the interfaces and every module.
package pai_pkg;

  localparam int unsigned PIX_W          = 12;
  localparam int unsigned DEPTH_W        = 32;
  localparam int unsigned BARY_W         = 17;
  localparam int unsigned W_W            = 32;
  localparam int unsigned ATTR_W         = 32;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned CORR_SHIFT     = 32;
  localparam int unsigned CQ_W           = BARY_W + CORR_SHIFT;
  localparam int unsigned SUM_W          = CQ_W + 2;
  localparam int unsigned DIV_STEPS      = 2;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned COORD_BITS_DEF = 12;

  typedef struct packed {
    logic [PIX_W-1:0]           x;
    logic [PIX_W-1:0]           y;
    logic [DEPTH_W-1:0]         depth;
    logic [2:0][ATTR_W-1:0]     attr;
  } pai_side_t;

endpackage

@@ rtl/pai_if.sv @@
// Valid/ready channel interfaces for fragment words in and result words out.
// Depends on pai_pkg.
interface pai_in_if;
  import pai_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [PIX_W-1:0]          pixel_x;
  logic [PIX_W-1:0]          pixel_y;
  logic signed [DEPTH_W-1:0] depth;
  logic [BARY_W-1:0]         bary0;
  logic [BARY_W-1:0]         bary1;
  logic [BARY_W-1:0]         bary2;
  logic [W_W-1:0]            w0;
  logic [W_W-1:0]            w1;
  logic [W_W-1:0]            w2;
  logic signed [ATTR_W-1:0]  attr_v0;
  logic signed [ATTR_W-1:0]  attr_v1;
  logic signed [ATTR_W-1:0]  attr_v2;

  modport source (output valid, pixel_x, pixel_y, depth, bary0, bary1, bary2,
                  w0, w1, w2, attr_v0, attr_v1, attr_v2, input ready);
  modport sink   (input valid, pixel_x, pixel_y, depth, bary0, bary1, bary2,
                  w0, w1, w2, attr_v0, attr_v1, attr_v2, output ready);
  modport monitor (input valid, ready, pixel_x, pixel_y, depth, bary0, bary1, bary2,
                   w0, w1, w2, attr_v0, attr_v1, attr_v2);
endinterface

interface pai_out_if;
  import pai_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [PIX_W-1:0]          out_x;
  logic [PIX_W-1:0]          out_y;
  logic signed [DEPTH_W-1:0] out_depth;
  logic signed [VAL_W-1:0]   interp_value;
  logic                      degenerate;

  modport source (output valid, out_x, out_y, out_depth, interp_value, degenerate,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_depth, interp_value, degenerate,
                  output ready);
  modport monitor (input valid, ready, out_x, out_y, out_depth, interp_value, degenerate);
endinterface

@@ rtl/perspective_attribute_interpolator.sv @@
// Top level of the perspective-correct attribute interpolator.
// Depends on pai_pkg, pai_if, pai_wdiv and pai_ndiv.
//
// Usage:
//   in_i carries one fragment attribute component per word: pixel position,
//   depth, three screen barycentric weights, three vertex w and three vertex
//   values. out_o returns one result word per input word, in order.
//   Throughput: one word per cycle. The whole pipeline advances together
//   whenever the output register is empty or being taken.
//   Stages: D1 = ceil(49 / 2) stages of the weight divider, the weight sum
//   register, D2 = ceil(FRAC_BITS / 2) + 1 stages of the normalising
//   divider, the multiply register and the output register. Both dividers are
//   restoring, two quotient bits per stage beyond the normalising integer stage.
//   Stall: while out_o.ready is low with a word waiting, in_i.ready drops and
//   every stage holds; nothing is lost or repeated.
//   Reset: rst_ni clears all valid bits; the pipeline comes up empty.
module perspective_attribute_interpolator #(
  parameter int unsigned FRAC_BITS  = pai_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_BITS = pai_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pai_in_if.sink     in_i,
  pai_out_if.source  out_o
);
  import pai_pkg::*;

  localparam int unsigned D1  = (CQ_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned D2  = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS + 1;
  localparam int unsigned LS  = D1 + D2 + 1;   // side band delay up to the multiplier
  localparam int unsigned Lat = LS + 2;
  localparam int unsigned PW  = FRAC_BITS + 2 + ATTR_W;
  localparam int unsigned AW  = PW + 2;
  localparam logic [PIX_W-1:0] CoordMask = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

  logic            en;
  logic [Lat-1:0]  v_q;

  // advance everything unless a finished word is stuck at the output
  assign en         = !v_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], in_i.valid};
    end
  end

  // corrected weights, one divider lane per vertex
  logic [BARY_W-1:0] bary [3];
  logic [W_W-1:0]    wv   [3];
  logic [CQ_W-1:0]   c_w  [3];

  assign bary[0] = in_i.bary0;
  assign bary[1] = in_i.bary1;
  assign bary[2] = in_i.bary2;
  assign wv[0]   = in_i.w0;
  assign wv[1]   = in_i.w1;
  assign wv[2]   = in_i.w2;

  for (genvar i = 0; i < 3; i++) begin : g_wdiv
    pai_wdiv u_wdiv (
      .clk_i  (clk_i),
      .en_i   (en),
      .bary_i (bary[i]),
      .w_i    (wv[i]),
      .c_o    (c_w[i])
    );
  end

  // weight sum stage
  logic [CQ_W-1:0]  c_q [3];
  logic [SUM_W-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_q[i] <= c_w[i];
      s_q <= SUM_W'(c_w[0]) + SUM_W'(c_w[1]) + SUM_W'(c_w[2]);
    end
  end

  // normalised weights
  logic [FRAC_BITS:0] n_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    pai_ndiv #(.FRAC_BITS(FRAC_BITS)) u_ndiv (
      .clk_i (clk_i),
      .en_i  (en),
      .c_i   (c_q[i]),
      .s_i   (s_q),
      .n_o   (n_w[i])
    );
  end

  // position, depth and vertex values travel alongside the dividers
  pai_side_t side_in;
  pai_side_t sb_q [LS];

  assign side_in.x       = in_i.pixel_x & CoordMask;
  assign side_in.y       = in_i.pixel_y & CoordMask;
  assign side_in.depth   = in_i.depth;
  assign side_in.attr[0] = in_i.attr_v0;
  assign side_in.attr[1] = in_i.attr_v1;
  assign side_in.attr[2] = in_i.attr_v2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= side_in;
      for (int k = 1; k < LS; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // multiply stage: one product per vertex
  logic signed [PW-1:0]  p_q [3];
  logic [PIX_W-1:0]      mx_q, my_q;
  logic [DEPTH_W-1:0]    mdepth_q;
  logic                  mdegen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= $signed({1'b0, n_w[i]}) * $signed(sb_q[LS-1].attr[i]);
      end
      mx_q     <= sb_q[LS-1].x;
      my_q     <= sb_q[LS-1].y;
      mdepth_q <= sb_q[LS-1].depth;
      mdegen_q <= (n_w[0] == '0) && (n_w[1] == '0) && (n_w[2] == '0);
    end
  end

  // accumulate, floor by arithmetic shift, saturate
  logic signed [AW-1:0]    acc, sh;
  logic signed [VAL_W-1:0] val_d;

  always_comb begin
    acc = AW'(p_q[0]) + AW'(p_q[1]) + AW'(p_q[2]);
    sh  = acc >>> FRAC_BITS;
    if (sh[AW-1:VAL_W-1] != '0 && sh[AW-1:VAL_W-1] != '1) begin
      val_d = sh[AW-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      val_d = sh[VAL_W-1:0];
    end
  end

  logic [PIX_W-1:0]        ox_q, oy_q;
  logic [DEPTH_W-1:0]      odepth_q;
  logic signed [VAL_W-1:0] oval_q;
  logic                    odegen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q     <= mx_q;
      oy_q     <= my_q;
      odepth_q <= mdepth_q;
      oval_q   <= val_d;
      odegen_q <= mdegen_q;
    end
  end

  assign out_o.valid        = v_q[Lat-1];
  assign out_o.out_x        = ox_q;
  assign out_o.out_y        = oy_q;
  assign out_o.out_depth    = odepth_q;
  assign out_o.interp_value = oval_q;
  assign out_o.degenerate   = odegen_q;

endmodule

@@ rtl/pai_wdiv.sv @@
// Pipelined restoring divider: corrected weight floor(bary * 2^32 / w).
// Depends on pai_pkg.
module pai_wdiv (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pai_pkg::BARY_W-1:0] bary_i,
  input  logic [pai_pkg::W_W-1:0]    w_i,
  output logic [pai_pkg::CQ_W-1:0]   c_o
);
  import pai_pkg::*;

  localparam int unsigned Stages = (CQ_W + DIV_STEPS - 1) / DIV_STEPS;

  logic [W_W-1:0]  r_q  [Stages];
  logic [CQ_W-1:0] qd_q [Stages];
  logic [W_W-1:0]  w_q  [Stages];

  for (genvar j = 0; j < Stages; j++) begin : g_st
    logic [W_W-1:0]  r_in, w_in, r_d;
    logic [CQ_W-1:0] qd_in, qd_d;

    if (j == 0) begin : g_head
      assign r_in  = '0;
      assign qd_in = {bary_i, {CORR_SHIFT{1'b0}}};
      assign w_in  = w_i;
    end else begin : g_body
      assign r_in  = r_q[j-1];
      assign qd_in = qd_q[j-1];
      assign w_in  = w_q[j-1];
    end

    always_comb begin
      logic [W_W:0] t;
      t    = '0;
      r_d  = r_in;
      qd_d = qd_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (j * DIV_STEPS + k < CQ_W) begin
          t = {r_d, qd_d[CQ_W-1]};
          if (t >= {1'b0, w_in}) begin
            t    = t - {1'b0, w_in};
            qd_d = {qd_d[CQ_W-2:0], 1'b1};
          end else begin
            qd_d = {qd_d[CQ_W-2:0], 1'b0};
          end
          r_d = t[W_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]  <= r_d;
        qd_q[j] <= qd_d;
        w_q[j]  <= w_in;
      end
    end
  end

  // a zero w contributes nothing
  assign c_o = (w_q[Stages-1] == '0) ? '0 : qd_q[Stages-1];

endmodule

@@ rtl/pai_ndiv.sv @@
// Pipelined restoring divider: normalised weight floor(c * 2^FRAC_BITS / s).
// Depends on pai_pkg.
module pai_ndiv #(
  parameter int unsigned FRAC_BITS = pai_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pai_pkg::CQ_W-1:0]  c_i,
  input  logic [pai_pkg::SUM_W-1:0] s_i,
  output logic [FRAC_BITS:0]        n_o
);
  import pai_pkg::*;

  localparam int unsigned Steps  = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned Stages = Steps + 1;

  logic [SUM_W-1:0]   r_q [Stages];
  logic [FRAC_BITS:0] q_q [Stages];
  logic [SUM_W-1:0]   s_q [Stages];

  for (genvar j = 0; j < Stages; j++) begin : g_st
    logic [SUM_W-1:0]   r_d, s_in;
    logic [FRAC_BITS:0] q_d;

    if (j == 0) begin : g_head
      logic [SUM_W-1:0] c_ext;
      assign c_ext = {{(SUM_W-CQ_W){1'b0}}, c_i};
      assign s_in  = s_i;
      // integer part: c never exceeds s, so one compare settles it
      always_comb begin
        if (c_ext >= s_i) begin
          r_d = c_ext - s_i;
          q_d = (FRAC_BITS+1)'(1);
        end else begin
          r_d = c_ext;
          q_d = '0;
        end
      end
    end else begin : g_body
      assign s_in = s_q[j-1];
      always_comb begin
        logic [SUM_W:0] t;
        t   = '0;
        r_d = r_q[j-1];
        q_d = q_q[j-1];
        for (int k = 0; k < DIV_STEPS; k++) begin
          if ((j - 1) * DIV_STEPS + k < FRAC_BITS) begin
            t = {r_d, 1'b0};
            if (t >= {1'b0, s_in}) begin
              t   = t - {1'b0, s_in};
              q_d = {q_d[FRAC_BITS-1:0], 1'b1};
            end else begin
              q_d = {q_d[FRAC_BITS-1:0], 1'b0};
            end
            r_d = t[SUM_W-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= r_d;
        q_q[j] <= q_d;
        s_q[j] <= s_in;
      end
    end
  end

  // zero sum: force the weight to zero, which flags the word degenerate
  assign n_o = (s_q[Stages-1] == '0) ? '0 : q_q[Stages-1];

endmodule

@@ rtl/pai_checker.sv @@
// Port-level checks on the perspective attribute interpolator, bound to the top.
// Depends on pai_pkg and perspective_attribute_interpolator_defines.svh.
`include "perspective_attribute_interpolator_defines.svh"

module pai_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_degenerate_i,
  input logic [pai_pkg::VAL_W-1:0] out_value_i
);

  `PAI_ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result word dropped while stalled")
  `PAI_ASSERT_CLK(a_stall_blocks, clk_i, rst_ni, out_valid_i && !out_ready_i |-> !in_ready_i, "input taken while output stalled")
  `PAI_ASSERT_CLK(a_ready_free, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input refused with output empty")
  `PAI_ASSERT_CLK(a_degen_zero, clk_i, rst_ni, out_valid_i && out_degenerate_i |-> out_value_i == '0, "degenerate word with nonzero value")
  `PAI_ASSERT_ANY(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_i, "result word during reset")

endmodule

bind perspective_attribute_interpolator pai_checker u_pai_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_degenerate_i (out_o.degenerate),
  .out_value_i      (out_o.interp_value)
);
